@@ sv/gsam_pkg.sv @@
// ----------------------------------------------------------------------------
// gsam_pkg
// Shared constants, types and helpers of the gain-saturating audio mixer.
// ----------------------------------------------------------------------------
package gsam_pkg;

    localparam int SOURCES            = 4;
    localparam int MAX_CHANNELS       = 8;
    localparam int GAIN_FRAC_BITS_DEF = 12;

    localparam int SAMPLE_W   = 32;
    localparam int GAIN_W     = 17;
    localparam int DEPTH_W    = 2;
    localparam int CHCNT_W    = 4;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int ACC_W      = SAMPLE_W + $clog2(SOURCES) + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ZERO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TWO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_THREE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DEPTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_DEPTHS  = 3'd7;

    // Depth codes; the code above 16 bit and the unused code both mean 32 bit.
    localparam logic [DEPTH_W-1:0] DEPTH_8  = 2'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_16 = 2'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_32 = 2'd2;

    localparam logic [SAMPLE_W-1:0] LIM8  = 32'd127;
    localparam logic [SAMPLE_W-1:0] LIM16 = 32'd32767;
    localparam logic [SAMPLE_W-1:0] LIM32 = 32'd2147483647;

    localparam int GAIN_LIMIT = 10;

    // Reset values of the configuration registers.
    localparam logic signed [GAIN_W-1:0]      GAIN_RESET       = 17'sd4096;
    localparam logic [DEPTH_W-1:0]            OUT_DEPTH_RESET  = DEPTH_16;
    localparam logic [CHCNT_W-1:0]            OUT_CHANS_RESET  = 4'd2;
    localparam logic [SOURCES*CHCNT_W-1:0]    SRC_CHANS_RESET  = 16'h2222;
    localparam logic [SOURCES*DEPTH_W-1:0]    SRC_DEPTHS_RESET = 8'h55;

    typedef struct packed {
        logic ld_mul;
        logic ld_term;
    } t_lane_ctl;

    typedef struct packed {
        logic [SOURCES-1:0] ld;
    } t_mrg_ctl;

    function automatic logic [SAMPLE_W-1:0] depth_limit(input logic [DEPTH_W-1:0] code);
        logic [SAMPLE_W-1:0] lim;
        case (code)
            DEPTH_8:  lim = LIM8;
            DEPTH_16: lim = LIM16;
            default:  lim = LIM32;
        endcase
        return lim;
    endfunction

endpackage

@@ sv/gsam_lane.sv @@
// ----------------------------------------------------------------------------
// gsam_lane
// One source lane: gain limit and multiply, then scale and saturate to depth.
// ----------------------------------------------------------------------------
module gsam_lane #(
    parameter int GAIN_FRAC_BITS = gsam_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  gsam_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [gsam_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic signed [gsam_pkg::GAIN_W-1:0]    i_gain,
    input  logic [gsam_pkg::DEPTH_W-1:0]          i_depth,
    input  logic                                  i_active,
    output logic signed [gsam_pkg::SAMPLE_W-1:0]  o_term,
    output logic                                  o_clip
);
    import gsam_pkg::*;

    localparam int GCMP_W = GAIN_W + GAIN_FRAC_BITS + 8;
    localparam logic signed [GCMP_W-1:0] GLIM = GCMP_W'(GAIN_LIMIT) << GAIN_FRAC_BITS;

    logic signed [GCMP_W-1:0]   gain_ext;
    logic signed [GAIN_W-1:0]   gain_lim;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_active;
    logic                       prod_neg;
    logic [PROD_W-1:0]          prod_mag;
    logic [PROD_W-1:0]          q_mag;
    logic [SAMPLE_W-1:0]        lim;
    logic                       sat;
    logic [SAMPLE_W-1:0]        m;
    logic signed [SAMPLE_W-1:0] n_term;
    logic                       n_clip;
    logic signed [SAMPLE_W-1:0] r_term;
    logic                       r_clip;

    // Gain is held to plus or minus ten before the multiply.
    always_comb begin
        gain_ext = GCMP_W'(i_gain);
        if (gain_ext > GLIM) begin
            gain_lim = GAIN_W'(GLIM);
        end else if (gain_ext < -GLIM) begin
            gain_lim = GAIN_W'(-GLIM);
        end else begin
            gain_lim = i_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            r_prod   <= PROD_W'(i_sample) * PROD_W'(gain_lim);
            r_active <= i_active;
        end
    end

    // Scale by magnitude so that the shift truncates toward zero.
    always_comb begin
        prod_neg = r_prod[PROD_W-1];
        prod_mag = prod_neg ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        q_mag    = prod_mag >> GAIN_FRAC_BITS;
        lim      = depth_limit(i_depth);
        sat      = q_mag > PROD_W'(lim);
        m        = sat ? lim : q_mag[SAMPLE_W-1:0];
        if (r_active) begin
            n_term = prod_neg ? -$signed(m) : $signed(m);
            n_clip = sat;
        end else begin
            n_term = '0;
            n_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_term) begin
            r_term <= n_term;
            r_clip <= n_clip;
        end
    end

    assign o_term = r_term;
    assign o_clip = r_clip;

endmodule

@@ sv/gsam_merge.sv @@
// ----------------------------------------------------------------------------
// gsam_merge
// Sums the lane terms in source order, one addition per stage, then clamps
// the sum to the output depth in the output register.
// ----------------------------------------------------------------------------
module gsam_merge (
    input  logic                                                 i_clk,
    input  gsam_pkg::t_mrg_ctl                                   i_ctl,
    input  logic signed [gsam_pkg::SOURCES-1:0][gsam_pkg::SAMPLE_W-1:0] i_term,
    input  logic [gsam_pkg::SOURCES-1:0]                         i_clip,
    input  logic [gsam_pkg::DEPTH_W-1:0]                         i_out_depth,
    output logic signed [gsam_pkg::SAMPLE_W-1:0]                 o_mixed,
    output logic                                                 o_clip
);
    import gsam_pkg::*;

    localparam logic signed [ACC_W-1:0] ALIM32 = ACC_W'(LIM32);

    logic                                       out32;
    logic signed [ACC_W-1:0]                    r_acc   [1:SOURCES-1];
    logic [SOURCES-1:0][SAMPLE_W-1:0]           r_terms [1:SOURCES-1];
    logic                                       r_clip  [1:SOURCES-1];
    logic signed [ACC_W-1:0]                    final_lim;
    logic signed [ACC_W-1:0]                    last_acc;
    logic signed [SAMPLE_W-1:0]                 n_mixed;
    logic                                       n_clip;
    logic signed [SAMPLE_W-1:0]                 r_mixed;
    logic                                       r_oclip;

    assign out32 = (i_out_depth != DEPTH_8) && (i_out_depth != DEPTH_16);

    genvar k;
    generate
        for (k = 1; k < SOURCES; k++) begin : g_add
            logic signed [ACC_W-1:0]          acc_in;
            logic signed [SAMPLE_W-1:0]       term_in;
            logic [SOURCES-1:0][SAMPLE_W-1:0] terms_in;
            logic                             clip_in;
            logic signed [ACC_W-1:0]          sum;
            logic signed [ACC_W-1:0]          n_acc;
            logic                             n_sclip;

            if (k == 1) begin : g_first
                assign acc_in   = ACC_W'($signed(i_term[0]));
                assign term_in  = i_term[1];
                assign terms_in = i_term;
                assign clip_in  = |i_clip;
            end else begin : g_rest
                assign acc_in   = r_acc[k-1];
                assign term_in  = $signed(r_terms[k-1][k]);
                assign terms_in = r_terms[k-1];
                assign clip_in  = r_clip[k-1];
            end

            // The running sum saturates at full scale only for 32-bit output.
            always_comb begin
                sum     = acc_in + ACC_W'(term_in);
                n_acc   = sum;
                n_sclip = clip_in;
                if (out32 && (sum > ALIM32)) begin
                    n_acc   = ALIM32;
                    n_sclip = 1'b1;
                end else if (out32 && (sum < -ALIM32)) begin
                    n_acc   = -ALIM32;
                    n_sclip = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ctl.ld[k-1]) begin
                    r_acc[k]   <= n_acc;
                    r_terms[k] <= terms_in;
                    r_clip[k]  <= n_sclip;
                end
            end
        end
    endgenerate

    always_comb begin
        final_lim = ACC_W'(depth_limit(i_out_depth));
        last_acc  = r_acc[SOURCES-1];
        n_clip    = r_clip[SOURCES-1];
        if (last_acc > final_lim) begin
            n_mixed = SAMPLE_W'(final_lim);
            n_clip  = 1'b1;
        end else if (last_acc < -final_lim) begin
            n_mixed = SAMPLE_W'(-final_lim);
            n_clip  = 1'b1;
        end else begin
            n_mixed = SAMPLE_W'(last_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[SOURCES-1]) begin
            r_mixed <= n_mixed;
            r_oclip <= n_clip;
        end
    end

    assign o_mixed = r_mixed;
    assign o_clip  = r_oclip;

endmodule

@@ sv/gain_saturating_audio_mixer_core.sv @@
// ----------------------------------------------------------------------------
// gain_saturating_audio_mixer_core
// Four-source audio mixer with per-source gain, depth saturation and a
// saturating sum clamped to the output depth.
// ----------------------------------------------------------------------------
// The block takes one interleaved output slot per clock when the input is
// not stalled, one sample per source, and returns one mixed sample per slot
// in order. Each request passes through a six-stage pipeline: the lane
// multiply, the lane scale and saturate, one addition stage for each source
// after the first, and the output clamp register; the result is presented
// from the output clamp register and is taken when the output is not
// stalled. A stall at the output backs up through the stages, filling empty
// stages first, so the input stalls only when the whole pipeline holds
// waiting requests. The channel counter advances when a request is accepted.
// Configuration must be written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module gain_saturating_audio_mixer_core #(
    parameter int GAIN_FRAC_BITS = gsam_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [gsam_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [gsam_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [gsam_pkg::SAMPLE_W-1:0]    i_sample_zero,
    input  logic signed [gsam_pkg::SAMPLE_W-1:0]    i_sample_one,
    input  logic signed [gsam_pkg::SAMPLE_W-1:0]    i_sample_two,
    input  logic signed [gsam_pkg::SAMPLE_W-1:0]    i_sample_three,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [gsam_pkg::SAMPLE_W-1:0]    o_mixed_sample,
    output logic [gsam_pkg::CNT_W-1:0]              o_channel_index,
    output logic                                    o_frame_end,
    output logic                                    o_clipped
);
    import gsam_pkg::*;

    localparam int NSTG = SOURCES + 2;

    logic signed [GAIN_W-1:0]           r_gain [SOURCES];
    logic [DEPTH_W-1:0]                 r_out_depth;
    logic [CHCNT_W-1:0]                 r_out_chans;
    logic [SOURCES*CHCNT_W-1:0]         r_src_chans;
    logic [SOURCES*DEPTH_W-1:0]         r_src_depths;

    logic [CNT_W-1:0]                   r_cnt;
    logic [CNT_W-1:0]                   n_cnt;
    logic [CHCNT_W-1:0]                 eff_chans;
    logic [CHCNT_W-1:0]                 cnt_p1;
    logic                               slot_last;
    logic [SOURCES-1:0]                 active;

    logic [NSTG-1:0]                    r_vld;
    logic [NSTG-1:0]                    free;
    logic [CNT_W-1:0]                   r_idx  [NSTG];
    logic                               r_last [NSTG];
    logic                               accept;

    logic signed [SAMPLE_W-1:0]         samples [SOURCES];
    logic signed [SOURCES-1:0][SAMPLE_W-1:0] terms;
    logic [SOURCES-1:0]                 lane_clip;
    t_lane_ctl                          lane_ctl;
    t_mrg_ctl                           mrg_ctl;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SOURCES; i++) begin
                r_gain[i] <= GAIN_RESET;
            end
            r_out_depth  <= OUT_DEPTH_RESET;
            r_out_chans  <= OUT_CHANS_RESET;
            r_src_chans  <= SRC_CHANS_RESET;
            r_src_depths <= SRC_DEPTHS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_GAIN_ZERO:  r_gain[0]    <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_GAIN_ONE:   r_gain[1]    <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_GAIN_TWO:   r_gain[2]    <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_GAIN_THREE: r_gain[3]    <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_OUT_DEPTH:  r_out_depth  <= i_cfg_data[DEPTH_W-1:0];
                REG_OUT_CHANS:  r_out_chans  <= i_cfg_data[CHCNT_W-1:0];
                REG_SRC_CHANS:  r_src_chans  <= i_cfg_data[SOURCES*CHCNT_W-1:0];
                REG_SRC_DEPTHS: r_src_depths <= i_cfg_data[SOURCES*DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Channel counter and per-slot source enables.
    always_comb begin
        if (r_out_chans == '0) begin
            eff_chans = CHCNT_W'(1);
        end else if (r_out_chans > CHCNT_W'(MAX_CHANNELS)) begin
            eff_chans = CHCNT_W'(MAX_CHANNELS);
        end else begin
            eff_chans = r_out_chans;
        end
        cnt_p1    = CHCNT_W'(r_cnt) + CHCNT_W'(1);
        slot_last = cnt_p1 >= eff_chans;
        n_cnt     = slot_last ? '0 : cnt_p1[CNT_W-1:0];
        for (int i = 0; i < SOURCES; i++) begin
            active[i] = r_src_chans[i*CHCNT_W +: CHCNT_W] > CHCNT_W'(r_cnt);
        end
    end

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        free[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG-2; k >= 0; k--) begin
            free[k] = !r_vld[k] || free[k+1];
        end
    end

    assign accept     = i_in_valid && free[0];
    assign o_in_stall = !free[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_cnt <= n_cnt;
            end
            if (free[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (free[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free[0]) begin
            r_idx[0]  <= r_cnt;
            r_last[0] <= slot_last;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (free[k]) begin
                r_idx[k]  <= r_idx[k-1];
                r_last[k] <= r_last[k-1];
            end
        end
    end

    assign samples[0] = i_sample_zero;
    assign samples[1] = i_sample_one;
    assign samples[2] = i_sample_two;
    assign samples[3] = i_sample_three;

    assign lane_ctl.ld_mul  = free[0];
    assign lane_ctl.ld_term = free[1];

    always_comb begin
        for (int m = 0; m < SOURCES; m++) begin
            mrg_ctl.ld[m] = free[m+2];
        end
    end

    genvar g;
    generate
        for (g = 0; g < SOURCES; g++) begin : g_lane
            gsam_lane #(
                .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_ctl    (lane_ctl),
                .i_sample (samples[g]),
                .i_gain   (r_gain[g]),
                .i_depth  (r_src_depths[g*DEPTH_W +: DEPTH_W]),
                .i_active (active[g]),
                .o_term   (terms[g]),
                .o_clip   (lane_clip[g])
            );
        end
    endgenerate

    gsam_merge u_merge (
        .i_clk       (i_clk),
        .i_ctl       (mrg_ctl),
        .i_term      (terms),
        .i_clip      (lane_clip),
        .i_out_depth (r_out_depth),
        .o_mixed     (o_mixed_sample),
        .o_clip      (o_clipped)
    );

    assign o_out_valid     = r_vld[NSTG-1];
    assign o_channel_index = r_idx[NSTG-1];
    assign o_frame_end     = r_last[NSTG-1];

endmodule

@@ tb/gsam_mix_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsam_mix_checker
// Watches the configuration port and both request channels of the mixer,
// keeps its own copy of the settings and the channel counter, predicts each
// mixed sample when a request is accepted and compares every accepted result
// in order against that prediction.
// ----------------------------------------------------------------------------
module gsam_mix_checker
    import gsam_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic signed [SAMPLE_W-1:0]  i_sample_zero,
    input  logic signed [SAMPLE_W-1:0]  i_sample_one,
    input  logic signed [SAMPLE_W-1:0]  i_sample_two,
    input  logic signed [SAMPLE_W-1:0]  i_sample_three,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [SAMPLE_W-1:0]  i_mixed_sample,
    input  logic [CNT_W-1:0]            i_channel_index,
    input  logic                        i_frame_end,
    input  logic                        i_clipped,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed;
        logic [CNT_W-1:0]           chan;
        logic                       frame_end;
        logic                       clipped;
    } mix_result;

    logic signed [GAIN_W-1:0]       gain [SOURCES];
    logic [DEPTH_W-1:0]             out_depth;
    logic [CHCNT_W-1:0]             out_chans;
    logic [SOURCES*CHCNT_W-1:0]     src_chans;
    logic [SOURCES*DEPTH_W-1:0]     src_depths;
    logic [CNT_W-1:0]               chan_count;

    mix_result  mixes_due [$];
    int         mismatches = 0;

    function automatic longint depth_cap(input logic [DEPTH_W-1:0] code);
        case (code)
            DEPTH_8:  return longint'(LIM8);
            DEPTH_16: return longint'(LIM16);
            default:  return longint'(LIM32);
        endcase
    endfunction

    function automatic longint sat_sym(input longint v, input longint lim, inout bit clip);
        if (v > lim) begin
            clip = 1'b1;
            return lim;
        end
        if (v < -lim) begin
            clip = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    // Mix one slot with the current settings and channel counter.
    function automatic mix_result mix_slot(input logic [SOURCES-1:0][SAMPLE_W-1:0] smp);
        mix_result r;
        longint    acc;
        longint    g;
        longint    p;
        longint    q;
        longint    glim;
        bit        clip;
        bit        wide;
        int        eff;
        glim = longint'(GAIN_LIMIT) <<< GAIN_FRAC_BITS_DEF;
        acc  = 0;
        clip = 1'b0;
        wide = (out_depth >= DEPTH_32);
        if (out_chans == 0)
            eff = 1;
        else if (out_chans > MAX_CHANNELS)
            eff = MAX_CHANNELS;
        else
            eff = int'(out_chans);
        for (int s = 0; s < SOURCES; s++) begin
            if (src_chans[CHCNT_W*s +: CHCNT_W] > {1'b0, chan_count}) begin
                g = longint'(gain[s]);
                if (g > glim)
                    g = glim;
                if (g < -glim)
                    g = -glim;
                p = longint'($signed(smp[s])) * g;
                // Scale down with truncation toward zero.
                if (p < 0)
                    q = -((-p) >>> GAIN_FRAC_BITS_DEF);
                else
                    q = p >>> GAIN_FRAC_BITS_DEF;
                q = sat_sym(q, depth_cap(src_depths[DEPTH_W*s +: DEPTH_W]), clip);
                acc += q;
                if (wide)
                    acc = sat_sym(acc, longint'(LIM32), clip);
            end
        end
        acc = sat_sym(acc, depth_cap(out_depth), clip);
        r.mixed     = acc[SAMPLE_W-1:0];
        r.chan      = chan_count;
        r.frame_end = (int'(chan_count) + 1 >= eff);
        r.clipped   = clip;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        mix_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < SOURCES; s++)
                gain[s] = GAIN_RESET;
            out_depth  = OUT_DEPTH_RESET;
            out_chans  = OUT_CHANS_RESET;
            src_chans  = SRC_CHANS_RESET;
            src_depths = SRC_DEPTHS_RESET;
            chan_count = '0;
            mixes_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_GAIN_ZERO:  gain[0] = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_ONE:   gain[1] = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_TWO:   gain[2] = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_THREE: gain[3] = i_cfg_data[GAIN_W-1:0];
                    REG_OUT_DEPTH:  out_depth = i_cfg_data[DEPTH_W-1:0];
                    REG_OUT_CHANS:  out_chans = i_cfg_data[CHCNT_W-1:0];
                    REG_SRC_CHANS:  src_chans = i_cfg_data[SOURCES*CHCNT_W-1:0];
                    REG_SRC_DEPTHS: src_depths = i_cfg_data[SOURCES*DEPTH_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (mixes_due.size() == 0) begin
                    $error("unexpected result: mixed_sample %0d, channel_index %0d",
                           i_mixed_sample, i_channel_index);
                    mismatches++;
                end else begin
                    want = mixes_due.pop_front();
                    if (i_mixed_sample !== want.mixed) begin
                        $error("mixed_sample: expected %0d, actual %0d",
                               $signed(want.mixed), i_mixed_sample);
                        mismatches++;
                    end
                    if (i_channel_index !== want.chan) begin
                        $error("channel_index: expected %0d, actual %0d",
                               want.chan, i_channel_index);
                        mismatches++;
                    end
                    if (i_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d",
                               want.frame_end, i_frame_end);
                        mismatches++;
                    end
                    if (i_clipped !== want.clipped) begin
                        $error("clipped: expected %0d, actual %0d",
                               want.clipped, i_clipped);
                        mismatches++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                want = mix_slot({i_sample_three, i_sample_two, i_sample_one, i_sample_zero});
                mixes_due.push_back(want);
                chan_count = want.frame_end ? '0 : chan_count + 1'b1;
            end
        end
        o_pending    <= mixes_due.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/gain_saturating_audio_mixer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_saturating_audio_mixer_core_tb
// Drives the mixer with directed slots at the extremes of gain, depth and
// channel settings, then with random slots under a series of random settings,
// with random idling on both channels; a checker module predicts and compares
// every result.
// ----------------------------------------------------------------------------
module gain_saturating_audio_mixer_core_tb;
    import gsam_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_SLOTS   = 160;

    // The unused depth code, which the block treats as 32 bit.
    localparam logic [DEPTH_W-1:0] DEPTH_SPARE = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [SOURCES-1:0][GAIN_W-1:0] gain;
        logic [DEPTH_W-1:0]             out_depth;
        logic [CHCNT_W-1:0]             out_chans;
        logic [SOURCES*CHCNT_W-1:0]     src_chans;
        logic [SOURCES*DEPTH_W-1:0]     src_depths;
    } mixer_setup;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_sample_zero = '0;
    logic signed [SAMPLE_W-1:0]  i_sample_one = '0;
    logic signed [SAMPLE_W-1:0]  i_sample_two = '0;
    logic signed [SAMPLE_W-1:0]  i_sample_three = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_mixed_sample;
    logic [CNT_W-1:0]            o_channel_index;
    logic                        o_frame_end;
    logic                        o_clipped;

    int fail_count;
    int mixes_pending;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    gain_saturating_audio_mixer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample_zero   (i_sample_zero),
        .i_sample_one    (i_sample_one),
        .i_sample_two    (i_sample_two),
        .i_sample_three  (i_sample_three),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_mixed_sample  (o_mixed_sample),
        .o_channel_index (o_channel_index),
        .o_frame_end     (o_frame_end),
        .o_clipped       (o_clipped)
    );

    gsam_mix_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_sample_zero   (i_sample_zero),
        .i_sample_one    (i_sample_one),
        .i_sample_two    (i_sample_two),
        .i_sample_three  (i_sample_three),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_mixed_sample  (o_mixed_sample),
        .i_channel_index (o_channel_index),
        .i_frame_end     (o_frame_end),
        .i_clipped       (o_clipped),
        .o_fail_count    (fail_count),
        .o_pending       (mixes_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Output side: after each accepted result, hold stall for a random count.
    always @(posedge i_clk) begin : result_sink
        int n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            n = rx_calm ? 0 : $urandom_range(0, 15);
            hold_left   <= n;
            i_out_stall <= (n != 0);
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= (hold_left > 1);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL gain_saturating_audio_mixer_core");
                $finish;
            end
        end
    end

    // Offers one slot and returns at the clock edge that accepts it.
    task automatic send_slot(input logic signed [SAMPLE_W-1:0] s0,
                             input logic signed [SAMPLE_W-1:0] s1,
                             input logic signed [SAMPLE_W-1:0] s2,
                             input logic signed [SAMPLE_W-1:0] s3);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_zero  <= s0;
        i_sample_one   <= s1;
        i_sample_two   <= s2;
        i_sample_three <= s3;
        // Stall is stable between edges, so look at it mid-cycle.
        do begin
            @(negedge i_clk);
        end while (o_in_stall);
        @(posedge i_clk);
    endtask

    // Holds off new requests until every mixed sample has come back.
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (mixes_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_setup(input mixer_setup st);
        put_reg(REG_GAIN_ZERO, st.gain[0]);
        put_reg(REG_GAIN_ONE, st.gain[1]);
        put_reg(REG_GAIN_TWO, st.gain[2]);
        put_reg(REG_GAIN_THREE, st.gain[3]);
        put_reg(REG_OUT_DEPTH, CFG_DATA_W'(st.out_depth));
        put_reg(REG_OUT_CHANS, CFG_DATA_W'(st.out_chans));
        put_reg(REG_SRC_CHANS, CFG_DATA_W'(st.src_chans));
        put_reg(REG_SRC_DEPTHS, CFG_DATA_W'(st.src_depths));
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] draw_gain();
        int v;
        case ($urandom_range(0, 5))
            0:       v = 40960;
            1:       v = -40960;
            2:       v = int'($urandom_range(0, 131071));
            3:       v = 4096;
            default: v = int'($urandom_range(0, 81920)) - 40960;
        endcase
        return v[GAIN_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        int v;
        case ($urandom_range(0, 7))
            0:       v = SMP_MAX;
            1:       v = SMP_MIN;
            2:       v = 0;
            3:       v = $urandom_range(0, 1) ? 1 : -1;
            4, 5:    v = $urandom;
            default: v = int'($urandom_range(0, 200000)) - 100000;
        endcase
        return v;
    endfunction

    function automatic mixer_setup draw_setup();
        mixer_setup st;
        for (int s = 0; s < SOURCES; s++) begin
            st.gain[s] = draw_gain();
            if ($urandom_range(0, 5) == 0)
                st.src_chans[CHCNT_W*s +: CHCNT_W] = CHCNT_W'($urandom_range(0, 15));
            else
                st.src_chans[CHCNT_W*s +: CHCNT_W] = CHCNT_W'($urandom_range(0, 8));
        end
        st.out_depth  = DEPTH_W'($urandom_range(0, 3));
        st.out_chans  = ($urandom_range(0, 4) == 0) ? CHCNT_W'($urandom_range(0, 15))
                                                    : CHCNT_W'($urandom_range(1, 8));
        st.src_depths = (SOURCES*DEPTH_W)'($urandom_range(0, 255));
        return st;
    endfunction

    initial begin : stimulus
        mixer_setup st;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Settings after reset: unity gains, 16 bit everywhere, two channels.
        send_slot(0, 0, 0, 0);
        send_slot(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
        send_slot(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);
        send_slot(1, -1, 32767, -32768);

        // Gains at and beyond ten, the spare depth code, eight channels.
        settle_pipeline();
        st.gain[0]    = 17'h0FFFF;
        st.gain[1]    = 17'h10000;
        st.gain[2]    = 17'sd40960;
        st.gain[3]    = -17'sd40960;
        st.out_depth  = DEPTH_SPARE;
        st.out_chans  = 4'd8;
        st.src_chans  = 16'h8888;
        st.src_depths = 8'hFF;
        apply_setup(st);
        send_slot(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
        send_slot(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);
        send_slot(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN);
        send_slot(1, 1, 1, 1);
        send_slot(-214748, 214748, 3, -3);

        // The counter now sits past the end of a two-channel frame.
        settle_pipeline();
        st.gain[0]    = 17'sd4096;
        st.gain[1]    = -17'sd4096;
        st.gain[2]    = 17'sd20480;
        st.gain[3]    = 17'sd4096;
        st.out_depth  = DEPTH_8;
        st.out_chans  = 4'd2;
        st.src_chans  = 16'h0F31;
        st.src_depths = 8'h1B;
        apply_setup(st);
        send_slot(100, 50, 20, 7);
        send_slot(100, 50, 20, 7);
        send_slot(-30, -100, 6, 9);
        send_slot(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN);

        // Tiny gains check truncation toward zero; fifteen channels act as eight.
        settle_pipeline();
        st.gain[0]    = 17'sd1;
        st.gain[1]    = -17'sd1;
        st.gain[2]    = 17'sd0;
        st.gain[3]    = 17'sd4095;
        st.out_depth  = DEPTH_32;
        st.out_chans  = 4'd15;
        st.src_chans  = 16'hFFFF;
        st.src_depths = 8'h00;
        apply_setup(st);
        send_slot(-1, -1, -1, -1);
        send_slot(4095, 4097, 5000, 4096);
        send_slot(-8191, 8191, 123, -4096);
        send_slot(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN);
        send_slot(SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX);
        send_slot(-4097, 4097, -123456, 123456);
        send_slot(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'shF0F0_F0F0);

        // No channels per frame acts as one; every source disabled.
        settle_pipeline();
        st.gain       = {SOURCES{17'sd4096}};
        st.out_depth  = DEPTH_16;
        st.out_chans  = 4'd0;
        st.src_chans  = 16'h0000;
        st.src_depths = 8'h55;
        apply_setup(st);
        send_slot(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
        send_slot(12345, -6789, 1, -1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle_pipeline();
            apply_setup(draw_setup());
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_SLOTS; k++) begin
                if (ph == 3 && k == PHASE_SLOTS / 2)
                    settle_pipeline();
                send_slot(draw_sample(), draw_sample(), draw_sample(), draw_sample());
            end
        end

        settle_pipeline();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && mixes_pending == 0)
            $display("PASS gain_saturating_audio_mixer_core");
        else
            $display("FAIL gain_saturating_audio_mixer_core");
        $finish;
    end

endmodule

@@ files.f @@
sv/gsam_pkg.sv
sv/gsam_lane.sv
sv/gsam_merge.sv
sv/gain_saturating_audio_mixer_core.sv
tb/gsam_mix_checker.sv
tb/gain_saturating_audio_mixer_core_tb.sv
